// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Next-cycle implication, disabled during reset.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// ----- sv/pdc_pkg.sv -----
// Package: types and constants of the PWM period and duty calculator.
`timescale 1ns / 1ps
package pdc_pkg;

	localparam int FREQ_W   = 32;
	localparam int DUTY_W   = 8;
	localparam int COUNT_W  = 16;
	localparam int CMP_W    = 17;
	localparam int DEN_W    = 49;
	localparam int CNT_W    = 5;

	localparam logic [31:0]        CLOCK_RESET  = 32'd72000000;
	localparam logic [COUNT_W-1:0] RELOAD_RESET = 16'hFFFF;
	localparam logic [6:0]         FULL_DUTY    = 7'd100;

	// Reciprocal of 100 scaled by 2^30, rounded up; exact for products below 2^23
	localparam logic [23:0]        DUTY_RECIP   = 24'd10737419;
	localparam int                 DUTY_SHIFT   = 30;

	localparam logic CMD_SETUP     = 1'b0;
	localparam logic CMD_DUTY_ONLY = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M_GO,
		S_M_WAIT,
		S_MF_MUL,
		S_Q_GO,
		S_Q_WAIT,
		S_CMP_MUL,
		S_CMP_SCALE,
		S_FINISH
	} pdc_state_t;

	typedef struct packed {
		logic                start;
		logic [FREQ_W-1:0]   dividend;
		logic [DEN_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [FREQ_W-1:0]   quotient;
	} div_rsp_t;

endpackage

// ----- sv/pdc_ifs.sv -----
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface pdc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [pdc_pkg::FREQ_W-1:0] frequency;
	logic [pdc_pkg::DUTY_W-1:0] duty;
	modport source (output valid, command, frequency, duty, input ready);
	modport sink (input valid, command, frequency, duty, output ready);
endinterface

interface pdc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [pdc_pkg::COUNT_W-1:0] prescaler;
	logic [pdc_pkg::COUNT_W-1:0] reload;
	logic [pdc_pkg::CMP_W-1:0]   compare;
	modport source (output valid, status, prescaler, reload, compare, input ready);
	modport sink (input valid, status, prescaler, reload, compare, output ready);
endinterface

interface pdc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pdc_pkg::FREQ_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/pdc_divider.sv -----
// Restoring divider: one quotient bit per cycle, 32 iterations, done pulsed after the last iteration.
`timescale 1ns / 1ps
module pdc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  pdc_pkg::div_req_t req,
	output pdc_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [pdc_pkg::CNT_W-1:0]     cnt_q;
	logic [pdc_pkg::FREQ_W-1:0]    rem_q;
	logic [pdc_pkg::FREQ_W-1:0]    quo_q;
	logic [pdc_pkg::DEN_W-1:0]     den_q;
	logic [pdc_pkg::FREQ_W:0]      trial;
	logic [pdc_pkg::DEN_W-1:0]     trial_wide;
	logic [pdc_pkg::DEN_W-1:0]     diff;
	logic                          fits;

	// Shift in the next dividend bit and trial-subtract
	assign trial      = {rem_q, quo_q[pdc_pkg::FREQ_W-1]};
	assign trial_wide = {{(pdc_pkg::DEN_W-pdc_pkg::FREQ_W-1){1'b0}}, trial};
	assign fits       = (trial_wide >= den_q);
	assign diff       = trial_wide - den_q;

	// Control: count iterations, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {pdc_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pdc_pkg::FREQ_W-1:0] : trial[pdc_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[pdc_pkg::FREQ_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- sv/pwm_period_duty_calculator_unit.sv -----
// Top level: PWM prescaler, reload and compare calculator with a shared divider.
// Set-up request: prescaler division, period division, then the compare steps; a failure skips to the result.
// Duty-only request: multiply, then reciprocal scale by 100.
// One request at a time: ready again the cycle after the result is registered; a held result
// stalls the finish.
// Reset: timer clock 72 MHz, prescaler 0, reload 65535, no result pending.
`timescale 1ns / 1ps
module pwm_period_duty_calculator_unit (
	input  logic       clk,
	input  logic       arst_n,
	pdc_req_if.sink    req,
	pdc_rsp_if.source  rsp,
	pdc_cfg_if.sink    cfg
);

	pdc_pkg::pdc_state_t            state_q;
	pdc_pkg::pdc_state_t            state_nx;
	pdc_pkg::div_req_t              div_req;
	pdc_pkg::div_rsp_t              div_rsp;

	logic [pdc_pkg::FREQ_W-1:0]     clock_q;
	logic [pdc_pkg::COUNT_W-1:0]    held_prescaler_q;
	logic [pdc_pkg::COUNT_W-1:0]    held_reload_q;
	logic                           out_valid_q;

	logic [pdc_pkg::FREQ_W-1:0]     freq_q;
	logic [6:0]                     duty_q;
	logic [pdc_pkg::FREQ_W-1:0]     num_q;
	logic [pdc_pkg::DEN_W-1:0]      den_q;
	logic [pdc_pkg::CMP_W-1:0]      m_q;
	logic [pdc_pkg::CMP_W-1:0]      op_q;
	logic                           fail_q;
	logic [pdc_pkg::CMP_W-1:0]      cmp_q;
	logic                           status_q;
	logic [pdc_pkg::COUNT_W-1:0]    prescaler_q;
	logic [pdc_pkg::COUNT_W-1:0]    reload_q;
	logic [pdc_pkg::CMP_W-1:0]      compare_q;

	logic                           accept;
	logic                           out_free;
	logic                           div_start;
	logic [6:0]                     duty_cap;
	logic [pdc_pkg::DEN_W-1:0]      freq_span;
	logic [pdc_pkg::DEN_W-1:0]      mf_prod;
	logic [23:0]                    duty_prod;
	logic [47:0]                    scale_prod;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign duty_cap = (req.duty > {1'b0, pdc_pkg::FULL_DUTY}) ? pdc_pkg::FULL_DUTY
	                                                         : req.duty[6:0];
	// f * 65537 as a shift and add
	assign freq_span = {1'b0, req.frequency, 16'b0}
	                 + {{(pdc_pkg::DEN_W-pdc_pkg::FREQ_W){1'b0}}, req.frequency};
	assign mf_prod   = {{(pdc_pkg::DEN_W-pdc_pkg::CMP_W){1'b0}}, m_q}
	                 * {{(pdc_pkg::DEN_W-pdc_pkg::FREQ_W){1'b0}}, freq_q};
	assign duty_prod = {{(24-pdc_pkg::CMP_W){1'b0}}, op_q} * {17'b0, duty_q};
	// Divide by 100 as a multiply by the scaled reciprocal
	assign scale_prod = {24'b0, num_q[23:0]} * {24'b0, pdc_pkg::DUTY_RECIP};

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pdc_pkg::S_IDLE: begin
				if (accept) begin
					if (req.command == pdc_pkg::CMD_DUTY_ONLY)
						state_nx = pdc_pkg::S_CMP_MUL;
					else if (req.frequency == '0)
						state_nx = pdc_pkg::S_FINISH;
					else
						state_nx = pdc_pkg::S_M_GO;
				end
			end
			pdc_pkg::S_M_GO:   state_nx = pdc_pkg::S_M_WAIT;
			pdc_pkg::S_M_WAIT: begin
				if (div_rsp.done)
					state_nx = (div_rsp.quotient[31:16] != '0) ? pdc_pkg::S_FINISH
					                                           : pdc_pkg::S_MF_MUL;
			end
			pdc_pkg::S_MF_MUL: state_nx = pdc_pkg::S_Q_GO;
			pdc_pkg::S_Q_GO:   state_nx = pdc_pkg::S_Q_WAIT;
			pdc_pkg::S_Q_WAIT: begin
				if (div_rsp.done)
					state_nx = (div_rsp.quotient == '0) ? pdc_pkg::S_FINISH
					                                    : pdc_pkg::S_CMP_MUL;
			end
			pdc_pkg::S_CMP_MUL:   state_nx = pdc_pkg::S_CMP_SCALE;
			pdc_pkg::S_CMP_SCALE: state_nx = pdc_pkg::S_FINISH;
			pdc_pkg::S_FINISH: begin
				if (out_free)
					state_nx = pdc_pkg::S_IDLE;
			end
			default: state_nx = pdc_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			pdc_pkg::S_IDLE: req.ready = 1'b1;
			pdc_pkg::S_M_GO: div_start = 1'b1;
			pdc_pkg::S_Q_GO: div_start = 1'b1;
			default: begin
				req.ready = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	// Control and held timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= pdc_pkg::S_IDLE;
			clock_q          <= pdc_pkg::CLOCK_RESET;
			held_prescaler_q <= '0;
			held_reload_q    <= pdc_pkg::RELOAD_RESET;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg.valid)
				clock_q <= cfg.data;
			if (state_q == pdc_pkg::S_Q_WAIT && div_rsp.done && div_rsp.quotient != '0) begin
				held_prescaler_q <= m_q[pdc_pkg::COUNT_W-1:0] - 1'b1;
				held_reload_q    <= div_rsp.quotient[pdc_pkg::COUNT_W-1:0] - 1'b1;
			end
			if (state_q == pdc_pkg::S_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Operands and intermediate results
	always_ff @(posedge clk) begin
		case (state_q)
			pdc_pkg::S_IDLE: begin
				if (accept) begin
					freq_q <= req.frequency;
					duty_q <= duty_cap;
					num_q  <= clock_q;
					den_q  <= freq_span;
					op_q   <= {1'b0, held_reload_q} + 1'b1;
					fail_q <= (req.command == pdc_pkg::CMD_SETUP) && (req.frequency == '0);
				end
			end
			pdc_pkg::S_M_WAIT: begin
				if (div_rsp.done) begin
					m_q    <= {1'b0, div_rsp.quotient[pdc_pkg::COUNT_W-1:0]} + 1'b1;
					fail_q <= (div_rsp.quotient[31:16] != '0);
				end
			end
			pdc_pkg::S_MF_MUL: den_q <= mf_prod;
			pdc_pkg::S_Q_WAIT: begin
				if (div_rsp.done) begin
					op_q   <= div_rsp.quotient[pdc_pkg::CMP_W-1:0];
					fail_q <= (div_rsp.quotient == '0);
				end
			end
			pdc_pkg::S_CMP_MUL: num_q <= {8'b0, duty_prod};
			pdc_pkg::S_CMP_SCALE: cmp_q <= scale_prod[pdc_pkg::DUTY_SHIFT +: pdc_pkg::CMP_W];
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == pdc_pkg::S_FINISH && out_free) begin
			status_q    <= fail_q ? pdc_pkg::STATUS_FAIL : pdc_pkg::STATUS_OK;
			prescaler_q <= held_prescaler_q;
			reload_q    <= held_reload_q;
			compare_q   <= fail_q ? '0 : cmp_q;
		end
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = num_q;
	assign div_req.divisor  = den_q;

	pdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.prescaler = prescaler_q;
	assign rsp.reload    = reload_q;
	assign rsp.compare   = compare_q;

endmodule

// ----- sv/pdc_checker.sv -----
// Checker on the top-level ports, bound to the calculator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_status,
	input logic [pdc_pkg::COUNT_W-1:0] rsp_reload,
	input logic [pdc_pkg::CMP_W-1:0]   rsp_compare
);

	logic [pdc_pkg::CMP_W-1:0] reload_span;
	assign reload_span = {1'b0, rsp_reload} + 1'b1;

	// One request in flight: drop ready after an accepted transaction
	`PDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// A failed request carries a zero compare value
	`PDC_ASSERT_IMPL(a_fail_zero_cmp, clk, arst_n, rsp_valid && rsp_status, rsp_compare == '0)
	// Compare never exceeds the period
	`PDC_ASSERT_IMPL(a_cmp_in_period, clk, arst_n, rsp_valid && !rsp_status, rsp_compare <= reload_span)
	// Hold a stalled result valid with a stable compare value
	`PDC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_compare))

endmodule

bind pwm_period_duty_calculator_unit pdc_checker u_pdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_reload  (rsp.reload),
	.rsp_compare (rsp.compare)
);
